// ===== hw/rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and helpers for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int DEF_VALUE_WIDTH = 64;
    localparam int IN_WIDTH        = 64;
    localparam int CHAR_WIDTH      = 6;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    // Decimal digits needed for the largest value of the given bit width.
    // 30103 / 100000 approximates log10(2); the product is never an integer.
    function automatic int num_digits(input int width);
        return (width * 30103) / 100000 + 1;
    endfunction

endpackage

// ===== hw/rtl/b2da_front.sv =====
// ----------------------------------------------------------------------------
// b2da_front
// Accepts one binary word, converts it to BCD with shift-add-3 at one bit per
// cycle, finds the most significant nonzero digit and hands both to the queue.
// ----------------------------------------------------------------------------
module b2da_front #(
    parameter int VALUE_WIDTH = b2da_pkg::DEF_VALUE_WIDTH,
    parameter int NUM_DIGITS  = b2da_pkg::num_digits(b2da_pkg::DEF_VALUE_WIDTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [b2da_pkg::IN_WIDTH-1:0]       i_value,
    output logic                                o_push_valid,
    input  logic                                i_push_stall,
    output logic [4*NUM_DIGITS-1:0]             o_bcd,
    output logic [$clog2(NUM_DIGITS)-1:0]       o_msd
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int MSD_W = $clog2(NUM_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PUSH
    } t_state;

    t_state                  r_state;
    logic [VALUE_WIDTH-1:0]  r_bin;
    logic [4*NUM_DIGITS-1:0] r_bcd;
    logic [CNT_W-1:0]        r_cnt;

    logic [4*NUM_DIGITS-1:0] adj_flat;
    logic [4*NUM_DIGITS-1:0] n_bcd;
    logic [MSD_W-1:0]        msd;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= b2da_pkg::BCD_ADJ_MIN) begin
                adj_flat[4*k +: 4] = r_bcd[4*k +: 4] + b2da_pkg::BCD_ADJ;
            end else begin
                adj_flat[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    assign n_bcd = {adj_flat[4*NUM_DIGITS-2:0], r_bin[VALUE_WIDTH-1]};

    // Highest nonzero digit; a zero value still gives one digit.
    always_comb begin
        msd = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) begin
                msd = MSD_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_bin   <= i_value[VALUE_WIDTH-1:0];
                        r_bcd   <= '0;
                        r_cnt   <= CNT_W'(VALUE_WIDTH - 1);
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_bcd <= n_bcd;
                    r_bin <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!i_push_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_push_valid = (r_state == ST_PUSH);
    assign o_bcd        = r_bcd;
    assign o_msd        = msd;

endmodule

// ===== hw/rtl/b2da_queue.sv =====
// ----------------------------------------------------------------------------
// b2da_queue
// Short register queue of converted words between the converter and the
// digit emitter.
// ----------------------------------------------------------------------------
module b2da_queue #(
    parameter int NUM_DIGITS = b2da_pkg::num_digits(b2da_pkg::DEF_VALUE_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push_valid,
    output logic                          o_push_stall,
    input  logic [4*NUM_DIGITS-1:0]       i_bcd,
    input  logic [$clog2(NUM_DIGITS)-1:0] i_msd,
    output logic                          o_pop_valid,
    input  logic                          i_pop,
    output logic [4*NUM_DIGITS-1:0]       o_bcd,
    output logic [$clog2(NUM_DIGITS)-1:0] o_msd
);

    localparam int MSD_W  = $clog2(NUM_DIGITS);
    localparam int DATA_W = 4*NUM_DIGITS + MSD_W;
    localparam int DEPTH  = b2da_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [FILL_W-1:0] r_fill;

    logic push;
    logic pop;

    assign o_push_stall = (r_fill == FILL_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign push         = i_push_valid && !o_push_stall;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= {i_bcd, i_msd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign {o_bcd, o_msd} = r_mem[r_rp];

endmodule

// ===== hw/rtl/b2da_back.sv =====
// ----------------------------------------------------------------------------
// b2da_back
// Takes converted words from the queue and emits their digits as ASCII, most
// significant first, one digit per cycle unless the output stalls, through an output register.
// ----------------------------------------------------------------------------
module b2da_back #(
    parameter int NUM_DIGITS = b2da_pkg::num_digits(b2da_pkg::DEF_VALUE_WIDTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    output logic                                o_q_pop,
    input  logic [4*NUM_DIGITS-1:0]             i_q_bcd,
    input  logic [$clog2(NUM_DIGITS)-1:0]       i_q_msd,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [b2da_pkg::CHAR_WIDTH-1:0]     o_digit_char,
    output logic                                o_last
);

    localparam int MSD_W = $clog2(NUM_DIGITS);

    logic [NUM_DIGITS-1:0][3:0]          r_bcd;
    logic [MSD_W-1:0]                    r_idx;
    logic                                r_busy;
    logic                                r_valid;
    logic [b2da_pkg::CHAR_WIDTH-1:0]     r_char;
    logic                                r_last;

    logic load;

    // The output register takes a new word when it is empty or being taken.
    assign load    = !r_valid || !i_stall;
    assign o_q_pop = !r_busy && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bcd <= i_q_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= i_q_msd;
            end else if (load && r_busy) begin
                r_idx <= r_idx - 1'b1;
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                end
            end
            if (load) begin
                r_valid <= r_busy;
                r_char  <= b2da_pkg::ASCII_ZERO + {2'b00, r_bcd[r_idx]};
                r_last  <= (r_idx == '0);
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

endmodule

// ===== hw/rtl/binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Unsigned binary to decimal ASCII digits, most significant digit first.
// ----------------------------------------------------------------------------
// One item carries an unsigned value, of which the low VALUE_WIDTH bits are
// converted. The block answers with the decimal digits of that value as ASCII
// characters, leading zeros dropped, one digit per word, and o_last marks the
// final digit; zero gives the single digit '0'. The converter takes the item
// in ST_IDLE, runs the shift-add-3 steps in ST_CONV and hands the result over
// in ST_PUSH, where a full queue can hold it, so it takes no new item before
// it is back in ST_IDLE. A two-entry queue separates it from the emitter,
// which sends one digit per cycle after loading a word from the queue, so the
// emitter keeps up unless the output side stalls.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = b2da_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [b2da_pkg::IN_WIDTH-1:0]       i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [b2da_pkg::CHAR_WIDTH-1:0]     o_digit_char,
    output logic                                o_last
);

    localparam int NUM_DIGITS = b2da_pkg::num_digits(VALUE_WIDTH);
    localparam int MSD_W      = $clog2(NUM_DIGITS);

    logic                    w_push_valid;
    logic                    w_push_stall;
    logic [4*NUM_DIGITS-1:0] w_push_bcd;
    logic [MSD_W-1:0]        w_push_msd;
    logic                    w_q_valid;
    logic                    w_q_pop;
    logic [4*NUM_DIGITS-1:0] w_q_bcd;
    logic [MSD_W-1:0]        w_q_msd;

    b2da_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_push_valid (w_push_valid),
        .i_push_stall (w_push_stall),
        .o_bcd        (w_push_bcd),
        .o_msd        (w_push_msd)
    );

    b2da_queue #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_stall (w_push_stall),
        .i_bcd        (w_push_bcd),
        .i_msd        (w_push_msd),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_bcd        (w_q_bcd),
        .o_msd        (w_q_msd)
    );

    b2da_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_q_pop),
        .i_q_bcd      (w_q_bcd),
        .i_q_msd      (w_q_msd),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    // Every emitted word is a decimal digit character.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= b2da_pkg::ASCII_ZERO) &&
                    (o_digit_char <= b2da_pkg::ASCII_ZERO + 6'd9))
        else $error("digit character out of range");

    // The converter is busy right after it takes a word.
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("converter not busy after accept");

    // A word handed to the queue is available to the emitter next cycle.
    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && !w_push_stall) |=> w_q_valid)
        else $error("queue lost a pushed word");

endmodule
